/* rtl/tnorm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tnorm_pkg
// Shared types and byte constants for the typography normaliser.
// ----------------------------------------------------------------------------
package tnorm_pkg;

    localparam int BYTE_W   = 8;
    localparam int OP_W     = 2;
    // Most output bytes one request can produce
    localparam int MAX_OUT  = 4;
    localparam int CNT_W    = $clog2(MAX_OUT + 1);
    // Candidate bytes from normalise/flush/verbatim, before the paragraph newlines
    localparam int NUM_CAND = 3;
    localparam int NUM_NL   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_NORMALIZE = 2'd0,
        OP_VERBATIM  = 2'd1,
        OP_FLUSH     = 2'd2,
        OP_PARA      = 2'd3
    } op_t;

    // UTF-8 lead and trail bytes
    localparam logic [BYTE_W-1:0] B_C2 = 8'hC2;
    localparam logic [BYTE_W-1:0] B_E2 = 8'hE2;
    localparam logic [BYTE_W-1:0] B_EF = 8'hEF;
    localparam logic [BYTE_W-1:0] B_BF = 8'hBF;
    localparam logic [BYTE_W-1:0] B_BB = 8'hBB;
    localparam logic [BYTE_W-1:0] B_AB = 8'hAB;
    localparam logic [BYTE_W-1:0] B_A0 = 8'hA0;
    localparam logic [BYTE_W-1:0] B_A6 = 8'hA6;
    localparam logic [BYTE_W-1:0] B_80 = 8'h80;
    localparam logic [BYTE_W-1:0] B_91 = 8'h91;
    localparam logic [BYTE_W-1:0] B_92 = 8'h92;
    localparam logic [BYTE_W-1:0] B_93 = 8'h93;
    localparam logic [BYTE_W-1:0] B_95 = 8'h95;
    localparam logic [BYTE_W-1:0] B_98 = 8'h98;
    localparam logic [BYTE_W-1:0] B_9B = 8'h9B;
    localparam logic [BYTE_W-1:0] B_9C = 8'h9C;
    localparam logic [BYTE_W-1:0] B_9F = 8'h9F;
    localparam logic [BYTE_W-1:0] B_B9 = 8'hB9;
    localparam logic [BYTE_W-1:0] B_BA = 8'hBA;

    // ASCII replacements
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;

endpackage : tnorm_pkg
`default_nettype wire

/* rtl/text_typography_normalizer_core.sv */
// Results of a request are registered and appear on the output in the cycle after it is accepted.
// Throughput: one request per cycle while each gives at most one byte and out_ready is high; a
//   request that gives more bytes (up to 4) holds off new requests until its last byte is taken,
//   set by the single output port draining the result buffer one byte per accepted output.
// Reset: asynchronous, active low; nothing held, last byte a newline, newline run 2,
//   nothing emitted yet, output buffer empty.
`default_nettype none
// ----------------------------------------------------------------------------
// text_typography_normalizer_core
// Byte-stream typography normaliser: folds UTF-8 quotes, dashes, NBSP and the
// ellipsis to ASCII, drops the BOM, collapses spaces/newlines, adds paragraph
// breaks. Up to four result bytes per request, drained from a small buffer.
// ----------------------------------------------------------------------------
module text_typography_normalizer_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [tnorm_pkg::OP_W-1:0]    operation,
    input  wire logic [tnorm_pkg::BYTE_W-1:0]  byte_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [tnorm_pkg::BYTE_W-1:0]       out_byte,
    output logic                               last_of_run
);
    import tnorm_pkg::*;

    // Normaliser state
    logic [BYTE_W-1:0] held0_reg, held0_next;
    logic [BYTE_W-1:0] held1_reg, held1_next;
    logic [1:0]        hc_reg, hc_next;
    logic [BYTE_W-1:0] last_reg, last_next;
    logic [1:0]        run_reg, run_next;
    logic              any_reg, any_next;

    // Result buffer, one request's bytes at a time, head at entry 0
    logic [BYTE_W-1:0] buf_reg [MAX_OUT];
    logic [BYTE_W-1:0] buf_next [MAX_OUT];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              in_acc;
    logic              out_acc;
    op_t               op;

    // Candidate bytes before collapsing
    logic [BYTE_W-1:0] cand_b [NUM_CAND];
    logic              cand_v [NUM_CAND];
    logic              cand_col;

    logic [BYTE_W-1:0] new_b [MAX_OUT];
    logic [CNT_W-1:0]  new_cnt;

    assign op        = op_t'(operation);
    assign out_valid = (cnt_reg != '0);
    assign out_byte  = buf_reg[0];
    assign last_of_run = (cnt_reg == CNT_W'(1));
    assign in_ready  = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_ready);
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;

    // Candidate generation: decode the request against the held prefix bytes
    always_comb
    begin
        logic [1:0] n;
        logic       done;
        n          = '0;
        done       = 1'b0;
        cand_col   = 1'b1;
        held0_next = held0_reg;
        held1_next = held1_reg;
        hc_next    = hc_reg;
        for (int i = 0; i < NUM_CAND; i++)
        begin
            cand_b[i] = '0;
            cand_v[i] = 1'b0;
        end
        case (op)
            OP_VERBATIM:
            begin
                cand_col  = 1'b0;
                cand_b[0] = byte_value;
                cand_v[0] = 1'b1;
            end
            OP_FLUSH, OP_PARA:
            begin
                hc_next = '0;
                if (hc_reg == 2'd1 || hc_reg == 2'd2)
                begin
                    cand_b[0] = held0_reg;
                    cand_v[0] = 1'b1;
                end
                if (hc_reg == 2'd2)
                begin
                    cand_b[1] = held1_reg;
                    cand_v[1] = 1'b1;
                end
            end
            OP_NORMALIZE:
            begin
                hc_next = '0;
                if (hc_reg == 2'd2)
                begin
                    // Three-byte sequences
                    if (held0_reg == B_E2)
                    begin
                        case (byte_value) inside
                            [B_98:B_9B]:
                            begin
                                cand_b[0] = CH_SQUOTE; cand_v[0] = 1'b1; done = 1'b1;
                            end
                            [B_9C:B_9F], B_B9, B_BA:
                            begin
                                cand_b[0] = CH_DQUOTE; cand_v[0] = 1'b1; done = 1'b1;
                            end
                            [B_93:B_95]:
                            begin
                                cand_b[0] = CH_DASH; cand_v[0] = 1'b1; done = 1'b1;
                            end
                            B_A6:
                            begin
                                for (int i = 0; i < NUM_CAND; i++)
                                begin
                                    cand_b[i] = CH_DOT;
                                    cand_v[i] = 1'b1;
                                end
                                done = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    else if (byte_value == B_BF)
                    begin
                        // byte order mark dropped
                        done = 1'b1;
                    end
                    if (!done)
                    begin
                        cand_b[0] = held0_reg; cand_v[0] = 1'b1;
                        cand_b[1] = held1_reg; cand_v[1] = 1'b1;
                        n = 2'd2;
                    end
                end
                else if (hc_reg == 2'd1)
                begin
                    // Two-byte sequences, or the second byte of a three-byte one
                    if (held0_reg == B_C2)
                    begin
                        case (byte_value) inside
                            B_A0:
                            begin
                                cand_b[0] = CH_SPACE; cand_v[0] = 1'b1; done = 1'b1;
                            end
                            B_AB, B_BB:
                            begin
                                cand_b[0] = CH_DQUOTE; cand_v[0] = 1'b1; done = 1'b1;
                            end
                            B_91, B_92:
                            begin
                                cand_b[0] = CH_SQUOTE; cand_v[0] = 1'b1; done = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    else if (byte_value == ((held0_reg == B_E2) ? B_80 : B_BB))
                    begin
                        held1_next = byte_value;
                        hc_next    = 2'd2;
                        done       = 1'b1;
                    end
                    if (!done)
                    begin
                        cand_b[0] = held0_reg; cand_v[0] = 1'b1;
                        n = 2'd1;
                    end
                end
                // New byte, with nothing held
                if (!done)
                begin
                    if (byte_value == B_C2 || byte_value == B_E2 || byte_value == B_EF)
                    begin
                        held0_next = byte_value;
                        hc_next    = 2'd1;
                    end
                    else
                    begin
                        cand_b[n] = byte_value;
                        cand_v[n] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Emitter chain: collapse candidates against the last byte, then add paragraph newlines
    always_comb
    begin
        logic [BYTE_W-1:0] b;
        logic              v;
        logic              col;
        logic              skip;
        last_next = last_reg;
        run_next  = run_reg;
        any_next  = any_reg;
        new_cnt   = '0;
        for (int i = 0; i < MAX_OUT; i++)
            new_b[i] = '0;
        for (int i = 0; i < NUM_CAND + NUM_NL; i++)
        begin
            if (i < NUM_CAND)
            begin
                b   = cand_b[i];
                v   = cand_v[i];
                col = cand_col;
            end
            else
            begin
                b   = CH_NL;
                v   = (op == OP_PARA) && any_next && (run_next != 2'd2);
                col = 1'b0;
            end
            skip = col && (((b == CH_SPACE) && (last_next == CH_SPACE || last_next == CH_NL))
                        || ((b == CH_NL) && (last_next == CH_NL)));
            if (v && !skip)
            begin
                if (new_cnt < CNT_W'(MAX_OUT))
                begin
                    new_b[new_cnt[CNT_W-2:0]] = b;
                    new_cnt = new_cnt + CNT_W'(1);
                end
                any_next  = 1'b1;
                last_next = b;
                if (b == CH_NL)
                    run_next = (run_next == 2'd2) ? 2'd2 : run_next + 2'd1;
                else
                    run_next = '0;
            end
        end
    end

    // Result buffer: load on accept, otherwise shift on each output request
    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_OUT; i++)
            buf_next[i] = buf_reg[i];
        if (in_acc)
        begin
            cnt_next = new_cnt;
            for (int i = 0; i < MAX_OUT; i++)
                buf_next[i] = new_b[i];
        end
        else if (out_acc)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            for (int i = 0; i < MAX_OUT - 1; i++)
                buf_next[i] = buf_reg[i + 1];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg   <= '0;
            last_reg <= CH_NL;
            run_reg  <= 2'd2;
            any_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_acc)
            begin
                hc_reg   <= hc_next;
                last_reg <= last_next;
                run_reg  <= run_next;
                any_reg  <= any_next;
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_OUT; i++)
            buf_reg[i] <= buf_next[i];
        if (in_acc)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

`ifndef SYNTHESIS
    // Buffer never holds more than one request's worth
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_OUT))
        else $error("result buffer count out of range");

    // At most two prefix bytes are ever held
    a_hc_range: assert property (@(posedge clk) disable iff (!rst_n)
        hc_reg != 2'd3)
        else $error("held count reached three");

    // A paragraph break after output leaves two trailing newlines
    a_para_nl: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (op == OP_PARA) && any_reg) |=> (run_reg == 2'd2 && last_reg == CH_NL))
        else $error("paragraph break did not leave two newlines");

    // Output empties before a new request is loaded
    a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (cnt_reg == '0 || (cnt_reg == CNT_W'(1) && out_acc)))
        else $error("request loaded over pending results");
`endif

endmodule : text_typography_normalizer_core
`default_nettype wire
